### rtl/button_hold_gesture_classifier_top_assert.svh
// Assertion macros shared by the button hold gesture classifier RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef BUTTON_HOLD_GESTURE_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_HOLD_GESTURE_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BHGC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define BHGC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bhgc_pkg.sv
// Package for the button hold gesture classifier: widths, register indexes,
// reset values, gesture codes and the configuration struct. No dependencies.
package bhgc_pkg;

   localparam int TimeWidth  = 32;
   localparam int CfgWidth   = 16;
   localparam int CsrIdxWidth = 2;
   localparam int GestWidth  = 2;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_RELEASE_SETTLE = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RECOVERY_MIN   = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_ADMIN_MIN      = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_ADMIN_MAX      = 2'd3;

   // Reset values
   localparam logic [CfgWidth-1:0] RELEASE_SETTLE_RST = 16'd50;
   localparam logic [CfgWidth-1:0] RECOVERY_MIN_RST   = 16'd8000;
   localparam logic [CfgWidth-1:0] ADMIN_MIN_RST      = 16'd1000;
   localparam logic [CfgWidth-1:0] ADMIN_MAX_RST      = 16'd4000;

   // Gesture codes
   localparam logic [GestWidth-1:0] GESTURE_NONE     = 2'd0;
   localparam logic [GestWidth-1:0] GESTURE_ADMIN    = 2'd1;
   localparam logic [GestWidth-1:0] GESTURE_RECOVERY = 2'd2;

   typedef struct packed {
      logic [CfgWidth-1:0] release_settle_ms;
      logic [CfgWidth-1:0] recovery_hold_min_ms;
      logic [CfgWidth-1:0] admin_hold_min_ms;
      logic [CfgWidth-1:0] admin_hold_max_ms;
   } cfg_type;

endpackage

### rtl/bhgc_if.sv
// Valid/ready channel interfaces for the button hold gesture classifier.
// Depends on bhgc_pkg for field widths.
interface bhgc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          button_down;
   logic [bhgc_pkg::TimeWidth-1:0] now_ms;

   modport source (output valid, output button_down, output now_ms, input ready);
   modport sink   (input valid, input button_down, input now_ms, output ready);
endinterface

interface bhgc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bhgc_pkg::GestWidth-1:0] gesture;

   modport source (output valid, output gesture, input ready);
   modport sink   (input valid, input gesture, output ready);
endinterface

### rtl/bhgc_core.sv
// Gesture state and classification for one button sample per cycle when step_en is set.
// Depends on bhgc_pkg and the assertion macro header.
`include "button_hold_gesture_classifier_top_assert.svh"

module bhgc_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  logic                           down,
   input  logic [bhgc_pkg::TimeWidth-1:0] now_ms,
   input  bhgc_pkg::cfg_type              cfg,
   output logic [bhgc_pkg::GestWidth-1:0] gesture
);
   import bhgc_pkg::*;

   logic                 armed_ff, armed_in;
   logic                 press_active_ff, press_active_in;
   logic                 release_pending_ff, release_pending_in;
   logic [TimeWidth-1:0] press_start_ff, press_start_in;
   logic [TimeWidth-1:0] release_start_ff, release_start_in;

   logic [TimeWidth-1:0] settle_ext;
   logic [TimeWidth-1:0] since_release;
   logic [TimeWidth-1:0] since_now;
   logic [TimeWidth-1:0] held;
   logic                 boot_settled;
   logic                 release_settled;

   assign settle_ext    = {{(TimeWidth-CfgWidth){1'b0}}, cfg.release_settle_ms};
   // before arming a fresh release starts now, so elapsed is zero
   assign since_now     = release_pending_ff ? (now_ms - release_start_ff) : '0;
   assign boot_settled  = since_now >= settle_ext;
   assign since_release = now_ms - release_start_ff;
   assign release_settled = since_release >= settle_ext;
   assign held          = release_start_ff - press_start_ff;

   // Advance the gesture state for the current sample
   always_comb begin
      armed_in           = armed_ff;
      press_active_in    = press_active_ff;
      release_pending_in = release_pending_ff;
      press_start_in     = press_start_ff;
      release_start_in   = release_start_ff;
      gesture            = GESTURE_NONE;

      if (!armed_ff) begin
         if (!down) begin
            if (!release_pending_ff) begin
               release_pending_in = 1'b1;
               release_start_in   = now_ms;
            end
            if (boot_settled) begin
               armed_in           = 1'b1;
               release_pending_in = 1'b0;
            end
         end else begin
            release_pending_in = 1'b0;
         end
      end else if (down) begin
         release_pending_in = 1'b0;
         if (!press_active_ff) begin
            press_active_in = 1'b1;
            press_start_in  = now_ms;
         end
      end else if (press_active_ff) begin
         if (!release_pending_ff) begin
            release_pending_in = 1'b1;
            release_start_in   = now_ms;
         end else if (release_settled) begin
            press_active_in    = 1'b0;
            release_pending_in = 1'b0;
            if (held >= {{(TimeWidth-CfgWidth){1'b0}}, cfg.recovery_hold_min_ms}) begin
               gesture = GESTURE_RECOVERY;
            end else if (held >= {{(TimeWidth-CfgWidth){1'b0}}, cfg.admin_hold_min_ms} &&
                         held <  {{(TimeWidth-CfgWidth){1'b0}}, cfg.admin_hold_max_ms}) begin
               gesture = GESTURE_ADMIN;
            end
         end
      end
   end

   // Hold control flags under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff           <= 1'b0;
         press_active_ff    <= 1'b0;
         release_pending_ff <= 1'b0;
      end else if (step_en) begin
         armed_ff           <= armed_in;
         press_active_ff    <= press_active_in;
         release_pending_ff <= release_pending_in;
      end
   end

   // Timestamps are only read once their flag is set
   always_ff @(posedge clock) begin
      if (step_en) begin
         press_start_ff   <= press_start_in;
         release_start_ff <= release_start_in;
      end
   end

   `BHGC_ASSERT_NOW(a_no_press_unarmed, clock, reset, !armed_ff, !press_active_ff, "press tracked before arming")
   `BHGC_ASSERT_NOW(a_pending_needs_press, clock, reset, armed_ff && release_pending_ff, press_active_ff, "release timed without a press")
   `BHGC_ASSERT_NOW(a_gesture_source, clock, reset, gesture != GESTURE_NONE, armed_ff && press_active_ff && release_pending_ff, "gesture without settled release")
   `BHGC_ASSERT_NEXT(a_gesture_clears, clock, reset, step_en && gesture != GESTURE_NONE, !press_active_ff && !release_pending_ff, "press not cleared after gesture")

endmodule

### rtl/button_hold_gesture_classifier_top.sv
// Button hold gesture classifier: input stage, configuration registers and
// result register around bhgc_core. Depends on bhgc_pkg, bhgc_if, bhgc_core.
//
// Takes one button sample per beat and returns exactly one gesture beat per
// sample (0 none, 1 admin, 2 recovery), in order. A sample passes through
// the input stage and then the result register; while the result side is not
// stalled a new sample can be taken at every clock, and a sample is still
// taken while a finished result waits, as long as the input stage is free.
// That throughput is set by the combinational update of the gesture state
// (one 32-bit subtract and compare per path). Write the
// csr_ registers only while no sample is in flight.
`include "button_hold_gesture_classifier_top_assert.svh"

module button_hold_gesture_classifier_top (
   input  logic                             clock,
   input  logic                             reset,
   bhgc_req_if.sink                         req_chan,
   bhgc_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [bhgc_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [bhgc_pkg::CfgWidth-1:0]    csr_wdata
);
   import bhgc_pkg::*;

   cfg_type              cfg_ff;
   logic                 s1_valid_ff;
   logic                 s1_down_ff;
   logic [TimeWidth-1:0] s1_now_ff;
   logic                 rsp_valid_ff;
   logic [GestWidth-1:0] gesture_ff;
   logic [GestWidth-1:0] gesture_in;
   logic                 advance;
   logic                 step_en;
   logic                 req_ready;

   assign advance   = !rsp_valid_ff || rsp_chan.ready;
   assign step_en   = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.gesture = gesture_ff;

   // Configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.release_settle_ms    <= RELEASE_SETTLE_RST;
         cfg_ff.recovery_hold_min_ms <= RECOVERY_MIN_RST;
         cfg_ff.admin_hold_min_ms    <= ADMIN_MIN_RST;
         cfg_ff.admin_hold_max_ms    <= ADMIN_MAX_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RELEASE_SETTLE: cfg_ff.release_settle_ms    <= csr_wdata;
            CSR_RECOVERY_MIN:   cfg_ff.recovery_hold_min_ms <= csr_wdata;
            CSR_ADMIN_MIN:      cfg_ff.admin_hold_min_ms    <= csr_wdata;
            CSR_ADMIN_MAX:      cfg_ff.admin_hold_max_ms    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input stage: take a beat when empty or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_chan.valid) begin
         s1_down_ff <= req_chan.button_down;
         s1_now_ff  <= req_chan.now_ms;
      end
   end

   bhgc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .down    (s1_down_ff),
      .now_ms  (s1_now_ff),
      .cfg     (cfg_ff),
      .gesture (gesture_in)
   );

   // Result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         gesture_ff <= gesture_in;
      end
   end

   `BHGC_ASSERT_NOW(a_no_take_when_full, clock, reset, s1_valid_ff && !advance, !req_chan.ready, "input stage overwritten while stalled")
   `BHGC_ASSERT_NEXT(a_step_gives_result, clock, reset, step_en, rsp_valid_ff, "processed sample produced no result")
   `BHGC_ASSERT_NEXT(a_empty_no_result, clock, reset, !s1_valid_ff && advance, !rsp_valid_ff, "result appeared without a sample")

endmodule

### bench/button_hold_gesture_classifier_top_tb.sv
// Self-checking bench for button_hold_gesture_classifier_top: a directed table, then random
// press/release sessions; each gesture beat checked against a table value or a gesture tracker.
// Depends on bhgc_pkg, bhgc_if and the RTL top level.
module button_hold_gesture_classifier_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bhgc_pkg::*;

   typedef logic [GestWidth-1:0] gesture_type;
   typedef logic [TimeWidth-1:0] stamp_type;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic                   down;
      stamp_type              now_ms;
      logic                   typed;
      gesture_type            gesture;
      logic [CsrIdxWidth-1:0] csr_idx;
      logic [CfgWidth-1:0]    csr_val;
   } stim_row_type;

   typedef struct packed {
      cfg_type    cfg;
      logic [7:0] send_idle_pct;
      logic [7:0] stall_pct;
   } phase_type;

   localparam int PhaseCount = 6;
   localparam int PhaseItems = 115;
   localparam int MaxReports = 10;
   localparam int HoldOffCycles = 150;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CfgWidth-1:0]    csr_wdata;

   bhgc_req_if req_if();
   bhgc_rsp_if rsp_if();

   button_hold_gesture_classifier_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Gesture tracker state and its copy of the registers
   cfg_type     trk_cfg;
   logic        trk_armed;
   logic        trk_press_active;
   logic        trk_release_pending;
   stamp_type   trk_press_start;
   stamp_type   trk_release_start;

   gesture_type pending_gestures[$];
   int unsigned samples_sent;
   int unsigned gesture_errors;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned hold_off_req;
   stamp_type   session_ms;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

   // Advance the tracker by one sample and return the gesture it ends
   function automatic gesture_type classify_sample(logic down, stamp_type now);
      stamp_type span;
      stamp_type held;
      if (!trk_armed) begin
         if (down) begin
            trk_release_pending = 1'b0;
         end else begin
            if (!trk_release_pending) begin
               trk_release_pending = 1'b1;
               trk_release_start = now;
            end
            span = now - trk_release_start;
            if (span >= stamp_type'(trk_cfg.release_settle_ms)) begin
               trk_armed = 1'b1;
               trk_release_pending = 1'b0;
            end
         end
         return GESTURE_NONE;
      end
      if (down) begin
         trk_release_pending = 1'b0;
         if (!trk_press_active) begin
            trk_press_active = 1'b1;
            trk_press_start = now;
         end
         return GESTURE_NONE;
      end
      if (!trk_press_active)
         return GESTURE_NONE;
      // the release edge only records its time
      if (!trk_release_pending) begin
         trk_release_pending = 1'b1;
         trk_release_start = now;
         return GESTURE_NONE;
      end
      span = now - trk_release_start;
      if (span < stamp_type'(trk_cfg.release_settle_ms))
         return GESTURE_NONE;
      held = trk_release_start - trk_press_start;
      trk_press_active = 1'b0;
      trk_release_pending = 1'b0;
      if (held >= stamp_type'(trk_cfg.recovery_hold_min_ms))
         return GESTURE_RECOVERY;
      if (held >= stamp_type'(trk_cfg.admin_hold_min_ms) &&
          held < stamp_type'(trk_cfg.admin_hold_max_ms))
         return GESTURE_ADMIN;
      return GESTURE_NONE;
   endfunction

   function automatic stim_row_type sample_row(logic down, stamp_type now, logic typed,
                                               gesture_type golden);
      return '{ROW_SAMPLE, down, now, typed, golden, CSR_RELEASE_SETTLE, '0};
   endfunction

   function automatic stim_row_type csr_row(logic [CsrIdxWidth-1:0] idx,
                                            logic [CfgWidth-1:0] val);
      return '{ROW_CSR, 1'b0, '0, 1'b0, GESTURE_NONE, idx, val};
   endfunction

   // Pick hold durations that straddle the thresholds, plus wide random ones
   function automatic stamp_type pick_hold();
      case ($urandom_range(0, 8))
         0: return stamp_type'(trk_cfg.recovery_hold_min_ms) - 1;
         1: return stamp_type'(trk_cfg.recovery_hold_min_ms);
         2: return stamp_type'(trk_cfg.admin_hold_min_ms) - 1;
         3: return stamp_type'(trk_cfg.admin_hold_min_ms);
         4: return stamp_type'(trk_cfg.admin_hold_max_ms) - 1;
         5: return stamp_type'(trk_cfg.admin_hold_max_ms);
         6: return $urandom;
         default: return $urandom_range(0, 70000);
      endcase
   endfunction

   task automatic check_gesture(gesture_type got);
      gesture_type want;
      if (pending_gestures.size() == 0) begin
         gesture_errors++;
         if (gesture_errors <= MaxReports)
            $display("%0t: gesture beat %0d with nothing pending", $realtime, got);
         return;
      end
      want = pending_gestures.pop_front();
      if (got !== want) begin
         gesture_errors++;
         if (gesture_errors <= MaxReports)
            $display("%0t: gesture mismatch, expected %0d, got %0d", $realtime, want, got);
      end
   endtask

   // Offer one sample, hold it until accepted, then queue its expected gesture
   task automatic send_sample(logic down, stamp_type now, logic typed = 1'b0,
                              gesture_type golden = GESTURE_NONE);
      gesture_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.button_down <= down;
      req_if.now_ms      <= now;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = classify_sample(down, now);
      pending_gestures.push_back(typed ? golden : predicted);
      samples_sent++;
   endtask

   // Drop valid and wait until every expected beat is back and the block is quiet
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_gestures.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [CsrIdxWidth-1:0] idx, logic [CfgWidth-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_RELEASE_SETTLE: trk_cfg.release_settle_ms = val;
         CSR_RECOVERY_MIN:   trk_cfg.recovery_hold_min_ms = val;
         CSR_ADMIN_MIN:      trk_cfg.admin_hold_min_ms = val;
         CSR_ADMIN_MAX:      trk_cfg.admin_hold_max_ms = val;
         default: ;
      endcase
   endtask

   // One press/release session with random content, sometimes preceded by raw noise
   task automatic play_session();
      stamp_type   press_ms;
      stamp_type   rel_ms;
      stamp_type   t;
      stamp_type   settle;
      int unsigned extra;
      settle = stamp_type'(trk_cfg.release_settle_ms);
      if ($urandom_range(0, 7) == 0) begin
         extra = $urandom_range(1, 3);
         repeat (extra) send_sample($urandom_range(0, 1) == 1, $urandom);
      end
      press_ms = session_ms + $urandom_range(1, 400);
      send_sample(1'b1, press_ms);
      t = press_ms;
      extra = $urandom_range(0, 3);
      repeat (extra) begin
         t = t + $urandom_range(0, 300);
         send_sample(1'b1, t);
      end
      rel_ms = press_ms + pick_hold();
      send_sample(1'b0, rel_ms);
      // bounce: a pressed sample while the release is timed, then a fresh edge
      if ($urandom_range(0, 4) == 0) begin
         send_sample(1'b1, rel_ms + $urandom_range(0, settle));
         rel_ms = rel_ms + $urandom_range(1, 500);
         send_sample(1'b0, rel_ms);
      end
      t = rel_ms;
      extra = $urandom_range(0, 2);
      repeat (extra) begin
         t = t + $urandom_range(0, settle / 3);
         send_sample(1'b0, t);
      end
      if (settle != 0 && $urandom_range(0, 1) == 1)
         send_sample(1'b0, rel_ms + settle - 1);
      t = rel_ms + settle + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 100) : 0);
      send_sample(1'b0, t);
      session_ms = t;
   endtask

   // Result side: check each beat, stall at random or for a requested stretch
   initial begin : result_side
      int unsigned hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            check_gesture(rsp_if.gesture);
         if (hold_off_req != 0) begin
            hold_left = hold_off_req;
            hold_off_req = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin : stimulus
      stim_row_type directed_rows [27];
      phase_type    phases [PhaseCount];
      int unsigned  phase_end;
      logic         hold_done;
      logic         drain_done;

      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_RELEASE_SETTLE;
      csr_wdata          <= '0;
      req_if.valid       <= 1'b0;
      req_if.button_down <= 1'b0;
      req_if.now_ms      <= '0;

      trk_cfg = '{RELEASE_SETTLE_RST, RECOVERY_MIN_RST, ADMIN_MIN_RST, ADMIN_MAX_RST};
      trk_armed = 1'b0;
      trk_press_active = 1'b0;
      trk_release_pending = 1'b0;
      trk_press_start = '0;
      trk_release_start = '0;
      session_ms = 32'd100000;

      directed_rows = '{
         // reset settle time: 49 ms released does not arm, a press restarts the wait
         sample_row(1'b0, 32'd100, 1'b1, GESTURE_NONE),
         sample_row(1'b0, 32'd149, 1'b1, GESTURE_NONE),
         sample_row(1'b1, 32'd160, 1'b1, GESTURE_NONE),
         // zero settle: arm on the first released sample, release edge still waits a sample
         csr_row(CSR_RELEASE_SETTLE, 16'd0),
         sample_row(1'b0, 32'd170, 1'b1, GESTURE_NONE),
         sample_row(1'b1, 32'd200, 1'b1, GESTURE_NONE),
         sample_row(1'b0, 32'd1200, 1'b1, GESTURE_NONE),
         sample_row(1'b0, 32'd1200, 1'b1, GESTURE_ADMIN),
         csr_row(CSR_RELEASE_SETTLE, RELEASE_SETTLE_RST),
         // held exactly the admin upper bound gives none
         sample_row(1'b1, 32'd3000, 1'b1, GESTURE_NONE),
         sample_row(1'b0, 32'd7000, 1'b1, GESTURE_NONE),
         sample_row(1'b0, 32'd7050, 1'b1, GESTURE_NONE),
         // held exactly the recovery minimum, one sample a ms short of settling
         sample_row(1'b1, 32'd10000, 1'b1, GESTURE_NONE),
         sample_row(1'b0, 32'd18000, 1'b1, GESTURE_NONE),
         sample_row(1'b0, 32'd18049, 1'b1, GESTURE_NONE),
         sample_row(1'b0, 32'd18050, 1'b1, GESTURE_RECOVERY),
         // bounce during settle keeps the original press start
         sample_row(1'b1, 32'd20000, 1'b1, GESTURE_NONE),
         sample_row(1'b0, 32'd21000, 1'b1, GESTURE_NONE),
         sample_row(1'b1, 32'd21010, 1'b1, GESTURE_NONE),
         sample_row(1'b0, 32'd22500, 1'b1, GESTURE_NONE),
         sample_row(1'b0, 32'd22550, 1'b1, GESTURE_ADMIN),
         // hold across the timestamp wrap
         sample_row(1'b1, 32'hFFFF_FFFF, 1'b0, GESTURE_NONE),
         sample_row(1'b0, 32'd1999, 1'b0, GESTURE_NONE),
         sample_row(1'b0, 32'd2049, 1'b0, GESTURE_NONE),
         // timestamp going backwards settles at once
         sample_row(1'b1, 32'd60000, 1'b0, GESTURE_NONE),
         sample_row(1'b0, 32'd62000, 1'b0, GESTURE_NONE),
         sample_row(1'b0, 32'd0, 1'b0, GESTURE_NONE)
      };

      phases = '{
         '{'{16'd50, 16'd8000, 16'd1000, 16'd4000}, 8'd0, 8'd0},
         '{'{16'd0, 16'd65535, 16'd0, 16'd65535}, 8'd51, 8'd0},
         '{'{16'd65535, 16'd0, 16'd2000, 16'd1000}, 8'd0, 8'd51},
         '{'{16'd7, 16'd3000, 16'd500, 16'd500}, 8'd17, 8'd17},
         '{'{16'd1, 16'd12000, 16'd65535, 16'd0}, 8'd51, 8'd0},
         '{'{16'd300, 16'd2500, 16'd1, 16'd2501}, 8'd0, 8'd51}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table with no idling
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_drained();
            write_register(directed_rows[i].csr_idx, directed_rows[i].csr_val);
         end else begin
            send_sample(directed_rows[i].down, directed_rows[i].now_ms,
                        directed_rows[i].typed, directed_rows[i].gesture);
         end
      end

      // Random sessions under each register setting and idling mix
      foreach (phases[p]) begin
         wait_drained();
         send_idle_pct = phases[p].send_idle_pct;
         stall_pct = phases[p].stall_pct;
         write_register(CSR_RELEASE_SETTLE, phases[p].cfg.release_settle_ms);
         write_register(CSR_RECOVERY_MIN, phases[p].cfg.recovery_hold_min_ms);
         write_register(CSR_ADMIN_MIN, phases[p].cfg.admin_hold_min_ms);
         write_register(CSR_ADMIN_MAX, phases[p].cfg.admin_hold_max_ms);
         phase_end = samples_sent + PhaseItems;
         hold_done = 1'b0;
         drain_done = 1'b0;
         while (samples_sent < phase_end) begin
            // hold off the result side while samples keep coming
            if (!hold_done && samples_sent >= phase_end - PhaseItems / 2) begin
               hold_off_req = HoldOffCycles;
               hold_done = 1'b1;
            end
            // pause the sender until every beat is back
            if (!drain_done && samples_sent >= phase_end - PhaseItems / 4) begin
               wait_drained();
               drain_done = 1'b1;
            end
            play_session();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (gesture_errors == 0 && pending_gestures.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
